>>> hdl/cpt_pkg.sv
// shared types, codes and saturating q16.16 arithmetic for the triangle closest-point block
package cpt_pkg;

  typedef logic signed [31:0] fx_t;
  typedef fx_t [2:0] vec_t;

  localparam fx_t FX_MAX = 32'sh7fffffff;
  localparam fx_t FX_MIN = 32'sh80000000;
  localparam fx_t FX_ONE = 32'sh00010000;

  typedef enum logic [2:0] {
    RG_VERT_A  = 3'd0,
    RG_VERT_B  = 3'd1,
    RG_EDGE_AB = 3'd2,
    RG_VERT_C  = 3'd3,
    RG_EDGE_AC = 3'd4,
    RG_EDGE_BC = 3'd5,
    RG_FACE    = 3'd6
  } region_e;

  // everything the back end needs alongside the divider
  typedef struct packed {
    region_e region;
    vec_t    a;
    vec_t    b;
    vec_t    c;
    vec_t    ab;
    vec_t    ac;
    vec_t    bc;
    fx_t     vb;
    fx_t     vc;
  } ctx_t;

  // clamp a 33 bit sum to 32 bits
  function automatic fx_t sat33(input logic signed [32:0] v);
    if (v[32] != v[31]) begin
      return v[32] ? FX_MIN : FX_MAX;
    end
    return fx_t'(v[31:0]);
  endfunction

  function automatic fx_t fx_add(input fx_t x, input fx_t y);
    logic signed [32:0] s;
    s = {x[31], x} + {y[31], y};
    return sat33(s);
  endfunction

  function automatic fx_t fx_sub(input fx_t x, input fx_t y);
    logic signed [32:0] s;
    s = {x[31], x} - {y[31], y};
    return sat33(s);
  endfunction

  // q16.16 product, round half away from zero, saturate
  function automatic fx_t fx_mul(input fx_t x, input fx_t y);
    logic signed [63:0] p;
    logic [63:0] m;
    logic [47:0] r;
    p = 64'(x) * 64'(y);
    m = p[63] ? 64'(-p) : 64'(p);
    r = 48'((m + 64'h8000) >> 16);
    if (!p[63]) begin
      return (r > 48'h7fffffff) ? FX_MAX : fx_t'(r[31:0]);
    end
    if (r >= 48'h80000000) begin
      return FX_MIN;
    end
    return -fx_t'(r[31:0]);
  endfunction

endpackage

>>> hdl/cpt_if.sv
// valid/ready channels for query words and result words
interface cpt_in_if;
  import cpt_pkg::*;
  logic valid;
  logic ready;
  fx_t  point_x;
  fx_t  point_y;
  fx_t  point_z;
  fx_t  vert_a_x;
  fx_t  vert_a_y;
  fx_t  vert_a_z;
  fx_t  vert_b_x;
  fx_t  vert_b_y;
  fx_t  vert_b_z;
  fx_t  vert_c_x;
  fx_t  vert_c_y;
  fx_t  vert_c_z;
  modport source (output valid, point_x, point_y, point_z, vert_a_x, vert_a_y, vert_a_z,
                  vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z,
                  input ready);
  modport sink (input valid, point_x, point_y, point_z, vert_a_x, vert_a_y, vert_a_z,
                vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z,
                output ready);
endinterface

interface cpt_out_if;
  import cpt_pkg::*;
  logic       valid;
  logic       ready;
  fx_t        closest_x;
  fx_t        closest_y;
  fx_t        closest_z;
  logic [2:0] region;
  modport source (output valid, closest_x, closest_y, closest_z, region, input ready);
  modport sink (input valid, closest_x, closest_y, closest_z, region, output ready);
endinterface

>>> hdl/closest_point_on_triangle.sv
// top level: closest point on a triangle, q16.16, fully pipelined
//
//   channel  dir  word
//   in_i     in   query point and vertices a, b, c (12 x 32 bit signed)
//   out_o    out  closest point (3 x 32 bit signed) and 3 bit region
//
// one word accepted per cycle while out_o is not stalled, one result word per query, in order
// 7 front stages, 34 divider stages, 3 back stages
// the divider, one quotient bit per stage, sets the depth
// a stall at out_o freezes the whole pipeline and drops in_i.ready
// reset clears only the valid bits
module closest_point_on_triangle (
  input logic       clk_i,
  input logic       rst_ni,
  cpt_in_if.sink    in_i,
  cpt_out_if.source out_o
);
  import cpt_pkg::*;

  logic    en;
  logic    f_vld, d_vld, b_vld;
  fx_t     num, den, t;
  ctx_t    f_ctx, d_ctx;
  vec_t    p_in, a_in, b_in, c_in, q;
  region_e region;

  // pipeline advances unless a finished word is held back
  assign en         = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  assign p_in = {in_i.point_z, in_i.point_y, in_i.point_x};
  assign a_in = {in_i.vert_a_z, in_i.vert_a_y, in_i.vert_a_x};
  assign b_in = {in_i.vert_b_z, in_i.vert_b_y, in_i.vert_b_x};
  assign c_in = {in_i.vert_c_z, in_i.vert_c_y, in_i.vert_c_x};

  cpt_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (in_i.valid),
    .p_i    (p_in),
    .a_i    (a_in),
    .b_i    (b_in),
    .c_i    (c_in),
    .vld_o  (f_vld),
    .num_o  (num),
    .den_o  (den),
    .ctx_o  (f_ctx)
  );

  cpt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (f_vld),
    .num_i  (num),
    .den_i  (den),
    .ctx_i  (f_ctx),
    .vld_o  (d_vld),
    .t_o    (t),
    .ctx_o  (d_ctx)
  );

  cpt_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .vld_i    (d_vld),
    .t_i      (t),
    .ctx_i    (d_ctx),
    .vld_o    (b_vld),
    .q_o      (q),
    .region_o (region)
  );

  // result word
  assign out_o.valid     = b_vld;
  assign out_o.closest_x = q[0];
  assign out_o.closest_y = q[1];
  assign out_o.closest_z = q[2];
  assign out_o.region    = 3'(region);

`ifndef NO_ASSERTIONS
  a_stall_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |-> !in_i.ready)
    else $error("input taken while result word is stalled");
  a_empty_open : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_o.valid |-> in_i.ready)
    else $error("input refused with no result word pending");
  a_word_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.closest_x) &&
    $stable(out_o.closest_y) && $stable(out_o.closest_z) && $stable(out_o.region))
    else $error("stalled result word changed");
`endif

endmodule

>>> hdl/cpt_front.sv
// edge vectors, dot products, region decision and divider operand selection
module cpt_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  cpt_pkg::vec_t p_i,
  input  cpt_pkg::vec_t a_i,
  input  cpt_pkg::vec_t b_i,
  input  cpt_pkg::vec_t c_i,
  output logic          vld_o,
  output cpt_pkg::fx_t  num_o,
  output cpt_pkg::fx_t  den_o,
  output cpt_pkg::ctx_t ctx_o
);
  import cpt_pkg::*;

  logic [5:0] vld_q;

  vec_t p0_q, a0_q, b0_q, c0_q;
  vec_t a1_q, b1_q, c1_q, ab1_q, ac1_q, bc1_q, ap1_q, bp1_q, cp1_q;
  vec_t a2_q, b2_q, c2_q, ab2_q, ac2_q, bc2_q;
  vec_t pr2_q [6];
  vec_t a3_q, b3_q, c3_q, ab3_q, ac3_q, bc3_q;
  fx_t  d3_q [6];
  vec_t a4_q, b4_q, c4_q, ab4_q, ac4_q, bc4_q;
  fx_t  d4_q [6];
  fx_t  mp4_q [6];
  vec_t a5_q, b5_q, c5_q, ab5_q, ac5_q, bc5_q;
  fx_t  d5_q [6];
  fx_t  va5_q, vb5_q, vc5_q, e5_q, f5_q, dab5_q, dac5_q, vab5_q;

  region_e region_d;
  fx_t     num_d, den_d;
  fx_t     d1, d2, d3, d4, d5, d6;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], vld_i};
      vld_o <= vld_q[5];
    end
  end

  // input word register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_q <= p_i;
      a0_q <= a_i;
      b0_q <= b_i;
      c0_q <= c_i;
    end
  end

  // edge and offset vectors
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q <= a0_q;
      b1_q <= b0_q;
      c1_q <= c0_q;
      for (int k = 0; k < 3; k++) begin
        ab1_q[k] <= fx_sub(b0_q[k], a0_q[k]);
        ac1_q[k] <= fx_sub(c0_q[k], a0_q[k]);
        bc1_q[k] <= fx_sub(c0_q[k], b0_q[k]);
        ap1_q[k] <= fx_sub(p0_q[k], a0_q[k]);
        bp1_q[k] <= fx_sub(p0_q[k], b0_q[k]);
        cp1_q[k] <= fx_sub(p0_q[k], c0_q[k]);
      end
    end
  end

  // component products of the six dot products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a2_q  <= a1_q;
      b2_q  <= b1_q;
      c2_q  <= c1_q;
      ab2_q <= ab1_q;
      ac2_q <= ac1_q;
      bc2_q <= bc1_q;
      for (int k = 0; k < 3; k++) begin
        pr2_q[0][k] <= fx_mul(ab1_q[k], ap1_q[k]);
        pr2_q[1][k] <= fx_mul(ac1_q[k], ap1_q[k]);
        pr2_q[2][k] <= fx_mul(ab1_q[k], bp1_q[k]);
        pr2_q[3][k] <= fx_mul(ac1_q[k], bp1_q[k]);
        pr2_q[4][k] <= fx_mul(ab1_q[k], cp1_q[k]);
        pr2_q[5][k] <= fx_mul(ac1_q[k], cp1_q[k]);
      end
    end
  end

  // dot product sums, left to right
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a3_q  <= a2_q;
      b3_q  <= b2_q;
      c3_q  <= c2_q;
      ab3_q <= ab2_q;
      ac3_q <= ac2_q;
      bc3_q <= bc2_q;
      for (int j = 0; j < 6; j++) begin
        d3_q[j] <= fx_add(fx_add(pr2_q[j][0], pr2_q[j][1]), pr2_q[j][2]);
      end
    end
  end

  // cross products of dots for the barycentric terms
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a4_q  <= a3_q;
      b4_q  <= b3_q;
      c4_q  <= c3_q;
      ab4_q <= ab3_q;
      ac4_q <= ac3_q;
      bc4_q <= bc3_q;
      d4_q  <= d3_q;
      mp4_q[0] <= fx_mul(d3_q[0], d3_q[3]);
      mp4_q[1] <= fx_mul(d3_q[2], d3_q[1]);
      mp4_q[2] <= fx_mul(d3_q[4], d3_q[1]);
      mp4_q[3] <= fx_mul(d3_q[0], d3_q[5]);
      mp4_q[4] <= fx_mul(d3_q[2], d3_q[5]);
      mp4_q[5] <= fx_mul(d3_q[4], d3_q[3]);
    end
  end

  // barycentric terms and edge divisors
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a5_q   <= a4_q;
      b5_q   <= b4_q;
      c5_q   <= c4_q;
      ab5_q  <= ab4_q;
      ac5_q  <= ac4_q;
      bc5_q  <= bc4_q;
      d5_q   <= d4_q;
      vc5_q  <= fx_sub(mp4_q[0], mp4_q[1]);
      vb5_q  <= fx_sub(mp4_q[2], mp4_q[3]);
      va5_q  <= fx_sub(mp4_q[4], mp4_q[5]);
      vab5_q <= fx_add(fx_sub(mp4_q[4], mp4_q[5]), fx_sub(mp4_q[2], mp4_q[3]));
      e5_q   <= fx_sub(d4_q[3], d4_q[2]);
      f5_q   <= fx_sub(d4_q[4], d4_q[5]);
      dab5_q <= fx_sub(d4_q[0], d4_q[2]);
      dac5_q <= fx_sub(d4_q[1], d4_q[5]);
    end
  end

  // region tests in priority order, pick divider operands
  always_comb begin
    d1 = d5_q[0];
    d2 = d5_q[1];
    d3 = d5_q[2];
    d4 = d5_q[3];
    d5 = d5_q[4];
    d6 = d5_q[5];
    if (d1 <= 0 && d2 <= 0) begin
      region_d = RG_VERT_A;
    end else if (d3 >= 0 && d4 <= d3) begin
      region_d = RG_VERT_B;
    end else if (vc5_q <= 0 && d1 >= 0 && d3 <= 0) begin
      region_d = RG_EDGE_AB;
    end else if (d6 >= 0 && d5 <= d6) begin
      region_d = RG_VERT_C;
    end else if (vb5_q <= 0 && d2 >= 0 && d6 <= 0) begin
      region_d = RG_EDGE_AC;
    end else if (va5_q <= 0 && e5_q >= 0 && f5_q >= 0) begin
      region_d = RG_EDGE_BC;
    end else begin
      region_d = RG_FACE;
    end
    case (region_d)
      RG_EDGE_AB: begin
        num_d = d1;
        den_d = dab5_q;
      end
      RG_EDGE_AC: begin
        num_d = d2;
        den_d = dac5_q;
      end
      RG_EDGE_BC: begin
        num_d = e5_q;
        den_d = fx_add(e5_q, f5_q);
      end
      default: begin
        num_d = FX_ONE;
        den_d = fx_add(vab5_q, vc5_q);
      end
    endcase
  end

  // divider operand register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_o        <= num_d;
      den_o        <= den_d;
      ctx_o.region <= region_d;
      ctx_o.a      <= a5_q;
      ctx_o.b      <= b5_q;
      ctx_o.c      <= c5_q;
      ctx_o.ab     <= ab5_q;
      ctx_o.ac     <= ac5_q;
      ctx_o.bc     <= bc5_q;
      ctx_o.vb     <= vb5_q;
      ctx_o.vc     <= vc5_q;
    end
  end

endmodule

>>> hdl/cpt_div.sv
// pipelined rounding q16.16 divider, one quotient bit per stage
module cpt_div (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  cpt_pkg::fx_t  num_i,
  input  cpt_pkg::fx_t  den_i,
  input  cpt_pkg::ctx_t ctx_i,
  output logic          vld_o,
  output cpt_pkg::fx_t  t_o,
  output cpt_pkg::ctx_t ctx_o
);
  import cpt_pkg::*;

  localparam int QW = 32;

  typedef struct packed {
    logic [49:0] rem;
    logic [32:0] dvs;
    logic [31:0] quo;
    logic        neg;
    logic        zero;
    logic        ovf;
    ctx_t        ctx;
  } dstage_t;

  dstage_t     st_q [QW+1];
  logic [QW:0] vld_q;

  logic [31:0] xm, ym;
  logic [49:0] n0;
  logic [32:0] dv0;
  logic [31:0] qc;
  fx_t         t_d;

  // operand set-up: magnitudes, doubled numerator plus divisor for rounding
  always_comb begin
    xm  = num_i[31] ? 32'(-num_i) : 32'(num_i);
    ym  = den_i[31] ? 32'(-den_i) : 32'(den_i);
    n0  = {1'b0, xm, 17'b0} + {18'b0, ym};
    dv0 = {ym, 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_q <= {vld_q[QW-1:0], vld_i};
      vld_o <= vld_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0].rem  <= n0;
      st_q[0].dvs  <= dv0;
      st_q[0].quo  <= '0;
      st_q[0].neg  <= num_i[31] ^ den_i[31];
      st_q[0].zero <= (den_i == '0);
      st_q[0].ovf  <= ({15'b0, n0[49:32]} >= dv0);
      st_q[0].ctx  <= ctx_i;
    end
  end

  // restoring steps, most significant quotient bit first
  for (genvar i = 0; i < QW; i++) begin : g_step
    localparam int K = QW - 1 - i;
    logic [64:0] dk;
    dstage_t     nx;
    always_comb begin
      dk = 65'(st_q[i].dvs) << K;
      nx = st_q[i];
      if ({15'b0, st_q[i].rem} >= dk) begin
        nx.rem    = st_q[i].rem - dk[49:0];
        nx.quo[K] = 1'b1;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[i+1] <= nx;
      end
    end
  end

  // clamp, sign and divide-by-zero code
  always_comb begin
    qc = st_q[QW].quo;
    if (st_q[QW].ovf || qc > 32'h80000000) begin
      qc = 32'h80000000;
    end
    if (st_q[QW].zero) begin
      t_d = FX_MIN;
    end else if (st_q[QW].neg) begin
      t_d = -fx_t'(qc);
    end else if (qc == 32'h80000000) begin
      t_d = FX_MAX;
    end else begin
      t_d = fx_t'(qc);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_o   <= t_d;
      ctx_o <= st_q[QW].ctx;
    end
  end

`ifndef NO_ASSERTIONS
  a_zero_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(en_i && vld_q[QW] && st_q[QW].zero) |-> t_o == FX_MIN)
    else $error("zero divisor did not give the most negative quotient");
`endif

endmodule

>>> hdl/cpt_back.sv
// edge projection and face reconstruction, final result select
module cpt_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  cpt_pkg::fx_t         t_i,
  input  cpt_pkg::ctx_t        ctx_i,
  output logic                 vld_o,
  output cpt_pkg::vec_t        q_o,
  output cpt_pkg::region_e     region_o
);
  import cpt_pkg::*;

  logic [1:0] vld_q;

  ctx_t ctx1_q, ctx2_q;
  vec_t base1_q, m1_q;
  fx_t  u1_q, w1_q;
  vec_t edge2_q, fa2_q, fb2_q;
  vec_t dir_d, base_d, q_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_q <= {vld_q[0], vld_i};
      vld_o <= vld_q[1];
    end
  end

  // pick the edge being projected onto
  always_comb begin
    case (ctx_i.region)
      RG_EDGE_AC: begin
        dir_d  = ctx_i.ac;
        base_d = ctx_i.a;
      end
      RG_EDGE_BC: begin
        dir_d  = ctx_i.bc;
        base_d = ctx_i.b;
      end
      default: begin
        dir_d  = ctx_i.ab;
        base_d = ctx_i.a;
      end
    endcase
  end

  // edge offsets and face weights
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctx1_q  <= ctx_i;
      base1_q <= base_d;
      u1_q    <= fx_mul(ctx_i.vb, t_i);
      w1_q    <= fx_mul(ctx_i.vc, t_i);
      for (int k = 0; k < 3; k++) begin
        m1_q[k] <= fx_mul(t_i, dir_d[k]);
      end
    end
  end

  // edge point and weighted face edges
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctx2_q <= ctx1_q;
      for (int k = 0; k < 3; k++) begin
        edge2_q[k] <= fx_add(base1_q[k], m1_q[k]);
        fa2_q[k]   <= fx_mul(ctx1_q.ab[k], u1_q);
        fb2_q[k]   <= fx_mul(ctx1_q.ac[k], w1_q);
      end
    end
  end

  // result select
  always_comb begin
    case (ctx2_q.region)
      RG_VERT_A: q_d = ctx2_q.a;
      RG_VERT_B: q_d = ctx2_q.b;
      RG_VERT_C: q_d = ctx2_q.c;
      RG_EDGE_AB, RG_EDGE_AC, RG_EDGE_BC: q_d = edge2_q;
      default: begin
        for (int k = 0; k < 3; k++) begin
          q_d[k] = fx_add(fx_add(ctx2_q.a[k], fa2_q[k]), fb2_q[k]);
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_o      <= q_d;
      region_o <= ctx2_q.region;
    end
  end

endmodule
